FILE: rtl/b64enc_pkg.sv
// Shared types, constants and the alphabet function of the base64 stream encoder.
`timescale 1ns / 1ps
`default_nettype none
package b64enc_pkg;

   localparam int CHAR_W = 8;
   localparam int CAP_W  = 16;
   localparam int MAX_CHARS = 4;

   localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_OK   = 2'd1,
      KIND_FAIL = 2'd2
   } kind_type;

   // One classified input item: the characters it produces, in order.
   typedef struct packed {
      logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
      logic [2:0]                        nchar;
      logic                              last;
   } job_type;

   // Standard alphabet lookup.
   function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
      logic [CHAR_W-1:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/b64enc_front.sv
// Front end: accepts input bytes and turns each into its list of characters.
`timescale 1ns / 1ps
`default_nettype none
module b64enc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] data_byte
   input  wire logic              req_tlast,   // is_last
   input  wire logic              push_ready,
   output logic                   push_valid,
   output b64enc_pkg::job_type    push_job
);

   logic [7:0] prev_ff, prev_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      push_job       = '0;
      push_job.last  = req_tlast;
      prev_in        = prev_ff;
      cnt_in         = cnt_ff;
      case (cnt_ff)
         2'd0: begin
            push_job.chars[0] = b64enc_pkg::sextet_char(req_tdata[7:2]);
            push_job.chars[1] = b64enc_pkg::sextet_char({req_tdata[1:0], 4'b0000});
            push_job.chars[2] = b64enc_pkg::PAD_CHAR;
            push_job.chars[3] = b64enc_pkg::PAD_CHAR;
            push_job.nchar    = req_tlast ? 3'd4 : 3'd1;
         end
         2'd1: begin
            push_job.chars[0] = b64enc_pkg::sextet_char({prev_ff[1:0], req_tdata[7:4]});
            push_job.chars[1] = b64enc_pkg::sextet_char({req_tdata[3:0], 2'b00});
            push_job.chars[2] = b64enc_pkg::PAD_CHAR;
            push_job.nchar    = req_tlast ? 3'd3 : 3'd1;
         end
         default: begin
            push_job.chars[0] = b64enc_pkg::sextet_char({prev_ff[3:0], req_tdata[7:6]});
            push_job.chars[1] = b64enc_pkg::sextet_char(req_tdata[5:0]);
            push_job.nchar    = 3'd2;
         end
      endcase
      if (accept) begin
         prev_in = req_tdata;
         if (req_tlast || cnt_ff == 2'd2) begin
            cnt_in = 2'd0;
         end else begin
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/b64enc_queue.sv
// Small job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module b64enc_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire b64enc_pkg::job_type push_job,
   output logic                     pop_valid,
   input  wire logic                pop,
   output b64enc_pkg::job_type      pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64enc_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/b64enc_back.sv
// Back end: emits characters against the capacity, end items, and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module b64enc_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [b64enc_pkg::CAP_W-1:0]   capacity,
   input  wire logic                           job_valid,
   input  wire b64enc_pkg::job_type            job,
   output logic                                job_pop,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [7:0] character
   output logic [1:0]                          rsp_tuser,  // [1:0] kind
   output logic                                rsp_tlast   // last
);

   typedef enum logic [1:0] {
      ST_CHAR = 2'b01,
      ST_END  = 2'b10
   } state_type;

   state_type                        state_ff, state_in;
   logic                             failed_ff, failed_in;
   logic [b64enc_pkg::CAP_W-1:0]     cw_ff, cw_in;
   logic [1:0]                       idx_ff, idx_in;
   logic                             valid_ff, valid_in;
   logic [7:0]                       char_ff, char_in;
   b64enc_pkg::kind_type             kind_ff, kind_in;
   logic                             last_ff, last_in;
   logic                             out_free, full;

   assign out_free   = !valid_ff || rsp_tready;
   assign full       = cw_ff >= capacity;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      state_in  = state_ff;
      failed_in = failed_ff;
      cw_in     = cw_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp_tready;
      char_in   = char_ff;
      kind_in   = kind_ff;
      last_in   = last_ff;
      job_pop   = 1'b0;
      unique case (state_ff)
         ST_CHAR: begin
            if (job_valid && failed_ff) begin
               job_pop = 1'b1;
               if (job.last) begin
                  failed_in = 1'b0;
               end
            end else if (job_valid && out_free) begin
               valid_in = 1'b1;
               if (full) begin
                  char_in   = 8'h00;
                  kind_in   = b64enc_pkg::KIND_FAIL;
                  last_in   = 1'b1;
                  cw_in     = '0;
                  idx_in    = 2'd0;
                  failed_in = !job.last;
                  job_pop   = 1'b1;
               end else begin
                  char_in = job.chars[idx_ff];
                  kind_in = b64enc_pkg::KIND_CHAR;
                  last_in = 1'b0;
                  cw_in   = cw_ff + 1'b1;
                  if ({1'b0, idx_ff} == job.nchar - 3'd1) begin
                     idx_in = 2'd0;
                     if (job.last) begin
                        state_in = ST_END;
                     end else begin
                        job_pop = 1'b1;
                     end
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
            end
         end
         ST_END: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = 8'h00;
               kind_in  = full ? b64enc_pkg::KIND_FAIL : b64enc_pkg::KIND_OK;
               last_in  = 1'b1;
               cw_in    = '0;
               job_pop  = 1'b1;
               state_in = ST_CHAR;
            end
         end
         default: begin
            state_in = ST_CHAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff  <= ST_CHAR;
         failed_ff <= 1'b0;
         cw_ff     <= '0;
         idx_ff    <= 2'd0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         failed_ff <= failed_in;
         cw_ff     <= cw_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/base64_stream_encoder_core.sv
// Top level of the base64 stream encoder: capacity register, front end, queue, back end.
//
// Usage:
//   req_*  : one message byte per item in req_tdata, req_tlast on its final byte.
//   rsp_*  : one result per item; rsp_tuser is the kind (0 character, 1 end ok,
//            2 end failed, buffer too small), rsp_tdata the character (0 on end
//            items), rsp_tlast high on the end item of a message.
//   csr_*  : writes the 16-bit output capacity (terminator place included);
//            write only while the encoder is idle. csr_ready is always high.
// An accepted item is first written into the queue; its characters then pass through the output register.
// Throughput: the back end emits one result per cycle unless rsp_tready stalls it; an item
//   yields 1 or 2 results inside a group and up to 5 on a final byte, about 4/3
//   results per byte on a long message. Dropped bytes yield no result.
// The queue of QUEUE_DEPTH jobs lets the input keep flowing while results wait.
// Reset: capacity returns to 1024, the queue, group and counters are cleared.
// A stall on rsp_tready holds the output register; the queue then fills and
//   req_tready falls.
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] character
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast,   // last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // [15:0] out_capacity
);

   logic [b64enc_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   logic                         push_valid, push_ready, pop_valid, pop;
   b64enc_pkg::job_type          push_job, pop_job;

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 16'd1024;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   b64enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   b64enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: rtl/b64enc_checker.sv
// Port-level assertions for the base64 stream encoder and their bind.
`timescale 1ns / 1ps
`default_nettype none
module b64enc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // End items and only end items close a message.
   a_last_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != b64enc_pkg::KIND_CHAR)))
      else $error("tlast does not match the item kind");

   // End items carry no character.
   a_end_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != b64enc_pkg::KIND_CHAR) |-> rsp_tdata == 8'h00)
      else $error("end item with nonzero data");

   // A stalled result holds.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // Reset empties the output register.
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind base64_stream_encoder_core b64enc_checker u_b64enc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
